/* hdl/btlv_pkg.sv */
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and codes for the BER-TLV request field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package btlv_pkg;

    // Field labels carried with every echoed byte
    localparam logic [2:0] FIELD_OTHER  = 3'd0;
    localparam logic [2:0] FIELD_SIGNED = 3'd1;
    localparam logic [2:0] FIELD_SIG    = 3'd2;
    localparam logic [2:0] FIELD_KEYID  = 3'd3;
    localparam logic [2:0] FIELD_CERT   = 3'd4;

    // Message status reported on the final byte
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_NO_TAG  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_MISSING = 3'd5;

    // One byte of the request message
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One labelled byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] field_code;
        logic       field_end;
        logic       done_res;
        logic [2:0] status;
    } t_out_item;

endpackage

`default_nettype wire

/* hdl/btlv_parser.sv */
// ----------------------------------------------------------------------------
// btlv_parser
// Parse state and the per-byte update: outer tag search, BER length decode,
// inner TLV walk, labeling and end-of-message status.
// ----------------------------------------------------------------------------
`default_nettype none

module btlv_parser
    import btlv_pkg::*;
#(
    parameter int LEN_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    output t_out_item      o_result
);

    localparam logic [3:0] PH_SEARCH = 4'd0;
    localparam logic [3:0] PH_OLEN1  = 4'd1;
    localparam logic [3:0] PH_OLEN2  = 4'd2;
    localparam logic [3:0] PH_TAG    = 4'd3;
    localparam logic [3:0] PH_TAG2   = 4'd4;
    localparam logic [3:0] PH_LEN1   = 4'd5;
    localparam logic [3:0] PH_LEN2   = 4'd6;
    localparam logic [3:0] PH_VAL    = 4'd7;
    localparam logic [3:0] PH_ERR    = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;

    localparam logic [7:0] TAG_OUTER_HI = 8'hBF;
    localparam logic [7:0] TAG_OUTER_LO = 8'h38;
    localparam logic [7:0] TAG_TWO_BYTE = 8'h5F;
    localparam logic [7:0] TAG_SIG_LO   = 8'h37;
    localparam logic [7:0] TAG_SEQ      = 8'h30;
    localparam logic [7:0] TAG_OCTETS   = 8'h04;

    localparam logic [6:0] MAX_LEN_BYTES = 7'd8;

    logic [3:0]          r_phase,  n_phase;
    logic                r_saw,    n_saw;
    logic [2:0]          r_cnt,    n_cnt;
    logic [LEN_BITS-1:0] r_acc,    n_acc;
    logic [3:0]          r_left,   n_left;
    logic [LEN_BITS-1:0] r_outer,  n_outer;
    logic [LEN_BITS-1:0] r_elem,   n_elem;
    logic [7:0]          r_tag,    n_tag;
    logic [3:0]          r_found,  n_found;
    logic [2:0]          r_field,  n_field;
    logic [2:0]          r_err,    n_err;

    logic [7:0]          b;
    logic [LEN_BITS-1:0] outer_dec;
    logic [LEN_BITS-1:0] elem_dec;
    logic [LEN_BITS-1:0] acc_pushed;
    logic [LEN_BITS-1:0] fin_len;
    logic [3:0]          left_dec;
    logic                acc_ok;
    logic                long_bad;
    logic [2:0]          hdr_label;
    logic [2:0]          tag_field;
    logic [2:0]          tag_label;
    logic                raise;
    logic [2:0]          raise_code;
    logic [2:0]          lab_field;
    logic                lab_end;
    logic [2:0]          st;

    assign b          = i_item.data_byte;
    assign outer_dec  = r_outer - LEN_BITS'(1);
    assign elem_dec   = r_elem - LEN_BITS'(1);
    assign left_dec   = r_left - 4'd1;
    // Accumulator may take another byte only while its top byte is clear
    assign acc_ok     = (r_acc[LEN_BITS-1 -: 8] == 8'd0);
    assign acc_pushed = LEN_BITS'({r_acc, b});
    assign long_bad   = (b[6:0] == 7'd0) || (b[6:0] > MAX_LEN_BYTES);
    assign hdr_label  = ((r_field == FIELD_SIGNED) || (r_field == FIELD_CERT)) ?
                        r_field : FIELD_OTHER;
    assign tag_label  = ((tag_field == FIELD_SIGNED) || (tag_field == FIELD_CERT)) ?
                        tag_field : FIELD_OTHER;
    assign fin_len    = (r_phase == PH_LEN1) ? LEN_BITS'(b[6:0]) : acc_pushed;

    // Pick the label of a newly opened inner TLV
    always_comb begin
        tag_field = FIELD_OTHER;
        if (b == TAG_SEQ) begin
            if (!r_found[0]) begin
                tag_field = FIELD_SIGNED;
            end else if (!r_found[3]) begin
                tag_field = FIELD_CERT;
            end
        end else if ((b == TAG_OCTETS) && !r_found[2]) begin
            tag_field = FIELD_KEYID;
        end
    end

    // Advance the parse by one byte
    always_comb begin
        n_phase    = r_phase;
        n_saw      = r_saw;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_left     = r_left;
        n_outer    = r_outer;
        n_elem     = r_elem;
        n_tag      = r_tag;
        n_found    = r_found;
        n_field    = r_field;
        n_err      = r_err;
        lab_field  = FIELD_OTHER;
        lab_end    = 1'b0;
        raise      = 1'b0;
        raise_code = ST_OK;
        st         = ST_OK;

        if (r_cnt < 3'd4) begin
            n_cnt = r_cnt + 3'd1;
        end

        case (r_phase)
            PH_SEARCH: begin
                if (r_saw && (b == TAG_OUTER_LO)) begin
                    n_saw   = 1'b0;
                    n_phase = PH_OLEN1;
                end else begin
                    n_saw = (b == TAG_OUTER_HI);
                end
            end
            PH_OLEN1: begin
                if (!b[7]) begin
                    n_outer = LEN_BITS'(b[6:0]);
                    n_phase = (b[6:0] != 7'd0) ? PH_TAG : PH_DONE;
                end else if (long_bad) begin
                    raise      = 1'b1;
                    raise_code = ST_BAD_LEN;
                end else begin
                    n_left  = b[3:0];
                    n_acc   = '0;
                    n_phase = PH_OLEN2;
                end
            end
            PH_OLEN2: begin
                if (!acc_ok) begin
                    raise      = 1'b1;
                    raise_code = ST_BAD_LEN;
                end else begin
                    n_acc  = acc_pushed;
                    n_left = left_dec;
                    if (left_dec == 4'd0) begin
                        n_outer = acc_pushed;
                        n_phase = (acc_pushed != '0) ? PH_TAG : PH_DONE;
                    end
                end
            end
            PH_TAG: begin
                n_outer = outer_dec;
                if (outer_dec == '0) begin
                    // lone trailing byte of outer content
                    n_phase = PH_DONE;
                end else begin
                    n_tag     = b;
                    n_field   = tag_field;
                    lab_field = tag_label;
                    case (tag_field)
                        FIELD_SIGNED: n_found[0] = 1'b1;
                        FIELD_CERT:   n_found[3] = 1'b1;
                        FIELD_KEYID:  n_found[2] = 1'b1;
                        default:      ;
                    endcase
                    n_phase = (b == TAG_TWO_BYTE) ? PH_TAG2 : PH_LEN1;
                end
            end
            PH_TAG2: begin
                n_outer = outer_dec;
                if ((r_tag == TAG_TWO_BYTE) && (b == TAG_SIG_LO) && !r_found[1]) begin
                    n_field    = FIELD_SIG;
                    n_found[1] = 1'b1;
                end
                if (outer_dec == '0) begin
                    raise      = 1'b1;
                    raise_code = ST_BAD_LEN;
                end else begin
                    n_phase = PH_LEN1;
                end
            end
            PH_LEN1, PH_LEN2: begin
                n_outer   = outer_dec;
                lab_field = hdr_label;
                if ((r_phase == PH_LEN1) && b[7]) begin
                    // long form: take the count of length bytes
                    if (long_bad || (outer_dec == '0)) begin
                        raise      = 1'b1;
                        raise_code = ST_BAD_LEN;
                    end else begin
                        n_left  = b[3:0];
                        n_acc   = '0;
                        n_phase = PH_LEN2;
                    end
                end else if ((r_phase == PH_LEN2) && !acc_ok) begin
                    raise      = 1'b1;
                    raise_code = ST_BAD_LEN;
                end else if ((r_phase == PH_LEN2) && (left_dec != 4'd0)) begin
                    n_acc  = acc_pushed;
                    n_left = left_dec;
                    if (outer_dec == '0) begin
                        raise      = 1'b1;
                        raise_code = ST_BAD_LEN;
                    end
                end else begin
                    // inner length complete
                    if (r_phase == PH_LEN2) begin
                        n_acc  = acc_pushed;
                        n_left = left_dec;
                    end
                    n_elem = fin_len;
                    if (fin_len > outer_dec) begin
                        raise      = 1'b1;
                        raise_code = ST_TRUNC;
                    end else if (fin_len == '0) begin
                        lab_end = (hdr_label != FIELD_OTHER);
                        n_field = FIELD_OTHER;
                        n_phase = (outer_dec != '0) ? PH_TAG : PH_DONE;
                    end else begin
                        n_phase = PH_VAL;
                    end
                end
            end
            PH_VAL: begin
                n_outer   = outer_dec;
                n_elem    = elem_dec;
                lab_field = r_field;
                if (elem_dec == '0) begin
                    lab_end = (r_field != FIELD_OTHER);
                    n_field = FIELD_OTHER;
                    n_phase = (outer_dec != '0) ? PH_TAG : PH_DONE;
                end
            end
            PH_ERR: begin
                if (r_outer != '0) begin
                    n_outer = outer_dec;
                end
            end
            default: ;
        endcase

        // Drop into the sticky error state
        if (raise) begin
            n_err     = raise_code;
            n_phase   = PH_ERR;
            n_field   = FIELD_OTHER;
            lab_field = FIELD_OTHER;
            lab_end   = 1'b0;
        end

        // Status of the message on its final byte
        if (i_item.last_byte) begin
            if (n_cnt < 3'd4) begin
                st = ST_SHORT;
            end else if ((n_phase == PH_SEARCH) || (n_phase == PH_OLEN1)) begin
                st = ST_NO_TAG;
            end else if (n_outer != '0) begin
                st = ST_TRUNC;
            end else if (n_err != ST_OK) begin
                st = n_err;
            end else if (n_phase == PH_OLEN2) begin
                st = ST_BAD_LEN;
            end else if (!(n_found[0] && n_found[1] && n_found[3])) begin
                st = ST_MISSING;
            end else begin
                st = ST_OK;
            end
        end
    end

    assign o_result.out_byte   = b;
    assign o_result.field_code = lab_field;
    assign o_result.field_end  = lab_end;
    assign o_result.done_res   = i_item.last_byte;
    assign o_result.status     = st;

    // Hold state, advance on each request, clear after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_byte)) begin
            r_phase <= PH_SEARCH;
            r_saw   <= 1'b0;
            r_cnt   <= 3'd0;
            r_acc   <= '0;
            r_left  <= 4'd0;
            r_outer <= '0;
            r_elem  <= '0;
            r_tag   <= 8'd0;
            r_found <= 4'd0;
            r_field <= FIELD_OTHER;
            r_err   <= ST_OK;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_saw   <= n_saw;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_outer <= n_outer;
            r_elem  <= n_elem;
            r_tag   <= n_tag;
            r_found <= n_found;
            r_field <= n_field;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

/* hdl/ber_tlv_request_field_extractor.sv */
// ----------------------------------------------------------------------------
// ber_tlv_request_field_extractor
// Labels each byte of a request message with the BER-TLV field it belongs to.
// ----------------------------------------------------------------------------
// Every request carries one message byte and produces one result: the byte
// echoed with a field label (signed part, signature, key id, certificate),
// a field-end flag, and on the final byte of the message its status. One
// byte is taken every clock cycle unless o_in_stall is high; a request is
// held in the input register, and the single parse-state update loads its
// result into the output register when the output side is free.
// Lengths wider than LEN_BITS are reported as bad length. State returns to
// reset after each final byte, so messages may follow with no gap.
`default_nettype none

module ber_tlv_request_field_extractor
    import btlv_pkg::*;
#(
    parameter int LEN_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out,
    input  wire logic      i_out_stall
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_ready;
    logic      fire;
    t_out_item result;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    btlv_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    // Load the input register unless it holds a stalled request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Capture the result while the output side is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled while output register can take a result");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed request produced no result");

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |-> r_out.done_res)
        else $error("status reported on a byte that does not end the message");

    a_end_needs_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.field_end) |-> (r_out.field_code != FIELD_OTHER))
        else $error("field end flagged on an unlabeled byte");
`endif

endmodule

`default_nettype wire
